// ----- sv/mthd_pkg.sv -----
// ----------------------------------------------------------------------------
// Message type header decoder package
// Shared constants, codes and beat types for the header decoder.
// ----------------------------------------------------------------------------
package mthd_pkg;

    // Short ids below this value are known message types
    localparam int NUM_SHORT_IDS = 33;
    // Length of the long-form type name field
    localparam int NAME_BYTES    = 12;

    localparam logic [8:0] SHORT_ID_LIMIT = 9'(NUM_SHORT_IDS);
    localparam logic [4:0] NAME_END       = 5'(NAME_BYTES);
    localparam logic [3:0] NAME_COUNT_MAX = 4'hF;

    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7F;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_NAME   = 2'd1,
        PH_ACCEPT = 2'd2,
        PH_REJECT = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_ID      = 3'd0,
        ROLE_NAME    = 3'd1,
        ROLE_PAD     = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_DROP    = 3'd4
    } role_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        role_t      byte_role;
        logic       verdict_now;
        logic       type_ok;
        logic [7:0] short_id;
        logic [3:0] name_length;
        logic       end_of_contents;
    } out_item_t;

endpackage

// ----- sv/mthd_if.sv -----
// ----------------------------------------------------------------------------
// Header decoder stream interfaces
// Valid/ready channels for input bytes and decoded result beats.
// ----------------------------------------------------------------------------
interface mthd_in_if;
    import mthd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface mthd_out_if;
    import mthd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    role_t      byte_role;
    logic       verdict_now;
    logic       type_ok;
    logic [7:0] short_id;
    logic [3:0] name_length;
    logic       end_of_contents;

    modport source (
        output valid, output byte_out, output byte_role, output verdict_now,
        output type_ok, output short_id, output name_length,
        output end_of_contents, input ready
    );
    modport sink (
        input valid, input byte_out, input byte_role, input verdict_now,
        input type_ok, input short_id, input name_length,
        input end_of_contents, output ready
    );
endinterface

// ----- sv/mthd_in_reg.sv -----
// ----------------------------------------------------------------------------
// Header decoder input register
// Captures one input beat and holds it until the decode stage takes it.
// ----------------------------------------------------------------------------
module mthd_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mthd_pkg::in_item_t in_item,
    output logic               held_valid,
    input  logic               advance,
    output mthd_pkg::in_item_t held_item
);
    import mthd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Take a new beat when empty or when the held one leaves this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;
endmodule

// ----- sv/mthd_core.sv -----
// ----------------------------------------------------------------------------
// Header decoder core
// Per-packet header state and the per-byte decode of role and verdict.
// ----------------------------------------------------------------------------
module mthd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  mthd_pkg::in_item_t  item,
    output mthd_pkg::out_item_t result
);
    import mthd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       zero_reg;
    logic       zero_next;
    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic [7:0] id_reg;
    logic [7:0] id_next;

    role_t      role;
    logic       verdict;
    logic       ok;
    logic       bad;
    logic [7:0] b;

    assign b = item.data_byte;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        zero_next  = zero_reg;
        count_next = count_reg;
        id_next    = id_reg;
        role       = ROLE_DROP;
        verdict    = 1'b0;
        ok         = 1'b0;
        bad        = 1'b0;

        unique case (phase_reg)
            PH_FIRST:
            begin
                role       = ROLE_ID;
                id_next    = b;
                pos_next   = 4'd0;
                zero_next  = 1'b0;
                count_next = 4'd0;
                if (b != 8'd0)
                begin
                    verdict    = 1'b1;
                    ok         = ({1'b0, b} < SHORT_ID_LIMIT);
                    phase_next = ok ? PH_ACCEPT : PH_REJECT;
                end
                else if (item.last)
                begin
                    verdict    = 1'b1;
                    phase_next = PH_REJECT;
                end
                else
                begin
                    phase_next = PH_NAME;
                end
            end
            PH_NAME:
            begin
                if (zero_reg)
                begin
                    role = ROLE_PAD;
                    bad  = (b != 8'd0);
                end
                else if (b == 8'd0)
                begin
                    role      = ROLE_PAD;
                    zero_next = 1'b1;
                end
                else
                begin
                    role = ROLE_NAME;
                    bad  = (b < PRINT_LOW) || (b > PRINT_HIGH);
                    if (!bad && count_reg < NAME_COUNT_MAX)
                    begin
                        count_next = count_reg + 4'd1;
                    end
                end

                priority if (bad)
                begin
                    verdict    = 1'b1;
                    phase_next = PH_REJECT;
                end
                else if (({1'b0, pos_reg} + 5'd1) >= NAME_END)
                begin
                    verdict    = 1'b1;
                    ok         = 1'b1;
                    phase_next = PH_ACCEPT;
                end
                else if (item.last)
                begin
                    // contents ended inside the name field
                    verdict    = 1'b1;
                    phase_next = PH_REJECT;
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            PH_ACCEPT:
            begin
                role = ROLE_PAYLOAD;
                ok   = 1'b1;
            end
            PH_REJECT:
            begin
                role = ROLE_DROP;
            end
            default:
            begin
                role = ROLE_DROP;
            end
        endcase

        // Rearm for the next packet
        if (item.last)
        begin
            phase_next = PH_FIRST;
            pos_next   = 4'd0;
            zero_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            pos_reg   <= 4'd0;
            zero_reg  <= 1'b0;
            count_reg <= 4'd0;
            id_reg    <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            zero_reg  <= zero_next;
            count_reg <= count_next;
            id_reg    <= id_next;
        end
    end

    always_comb
    begin
        result.byte_out        = b;
        result.byte_role       = role;
        result.verdict_now     = verdict;
        result.type_ok         = ok;
        result.short_id        = id_next;
        result.name_length     = count_next;
        result.end_of_contents = item.last;
    end
endmodule

// ----- sv/mthd_out_reg.sv -----
// ----------------------------------------------------------------------------
// Header decoder result register
// Holds one decoded result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module mthd_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    output logic                load_ready,
    input  mthd_pkg::out_item_t load_item,
    output logic                out_valid,
    input  logic                out_ready,
    output mthd_pkg::out_item_t out_item
);
    import mthd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = (load_valid && load_ready) ? 1'b1 :
                        (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            item_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

// ----- sv/message_type_header_decoder_top.sv -----
// ----------------------------------------------------------------------------
// Message type header decoder
// Decodes the message type header of decrypted packet contents, byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_stream carries one contents byte per beat, with last on the final
//   byte of a packet. out_stream returns exactly one result beat per input
//   beat, in order: the byte, its role (id, name, padding, payload, dropped),
//   the verdict flag and outcome, the short id, the running name length and
//   a copy of last.
//   Each beat passes through the input register and then the result register
//   on its way to out_stream. Throughput is one byte per cycle while the
//   receiver does not stall; the decode is a single compare-and-count step per byte.
//   Reset empties both registers and arms the decoder for the first byte of
//   a packet. When the receiver stalls, the result register holds its beat,
//   the input register still takes one more beat, and in_stream.ready drops
//   only once both are full. A beat with last returns the decoder to the
//   start of a new packet.
// ----------------------------------------------------------------------------
module message_type_header_decoder_top (
    input logic       clk,
    input logic       rst_n,
    mthd_in_if.sink   in_stream,
    mthd_out_if.source out_stream
);
    import mthd_pkg::*;

    in_item_t  in_item;
    in_item_t  held_item;
    logic      held_valid;
    logic      advance;
    logic      load_ready;
    out_item_t decoded;
    out_item_t result;

    assign in_item.data_byte = in_stream.data_byte;
    assign in_item.last      = in_stream.last;

    // A held byte is decoded in the cycle it moves into the result register
    assign advance = held_valid && load_ready;

    mthd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_stream.valid),
        .in_ready   (in_stream.ready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .advance    (advance),
        .held_item  (held_item)
    );

    mthd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .result  (decoded)
    );

    mthd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (held_valid),
        .load_ready (load_ready),
        .load_item  (decoded),
        .out_valid  (out_stream.valid),
        .out_ready  (out_stream.ready),
        .out_item   (result)
    );

    assign out_stream.byte_out        = result.byte_out;
    assign out_stream.byte_role       = result.byte_role;
    assign out_stream.verdict_now     = result.verdict_now;
    assign out_stream.type_ok         = result.type_ok;
    assign out_stream.short_id        = result.short_id;
    assign out_stream.name_length     = result.name_length;
    assign out_stream.end_of_contents = result.end_of_contents;
endmodule
